/* design/normal_angle_deviation_tracker_defines.svh */
// Assertion macros used by the top-level design file.
`ifndef NORMAL_ANGLE_DEVIATION_TRACKER_DEFINES_SVH
`define NORMAL_ANGLE_DEVIATION_TRACKER_DEFINES_SVH
`ifndef ASSERT_OFF
`define NADT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define NADT_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define NADT_ASSERT_IMP(lbl, ante, cons, msg)
`define NADT_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

/* design/nadt_pkg.sv */
package nadt_pkg;

  localparam int COMP_W   = 16;
  localparam int OPND_W   = 33;
  localparam int PROD_W   = 2 * OPND_W;
  localparam int DOT_W    = 34;
  localparam int RAD_W    = 64;
  localparam int ROOT_W   = 32;
  localparam int XY_W     = 36;
  localparam int ACC_W    = 26;
  localparam int ANGLE_W  = 16;
  localparam int IDX_W    = 21;
  localparam int TOL_W    = 8;
  localparam int CORDIC_STEPS = 20;
  localparam int MUL_OPS  = 12;

  localparam logic [IDX_W-1:0]        MAX_TRIANGLES = IDX_W'(1048576);
  localparam logic signed [ACC_W-1:0] DEG90  = ACC_W'(5898240);
  localparam logic signed [ACC_W-1:0] DEG180 = ACC_W'(11796480);

  typedef logic signed [COMP_W-1:0] comp_t;
  typedef logic [ANGLE_W-1:0]       angle_t;

  function automatic logic signed [ACC_W-1:0] atan_step(input logic [4:0] i);
    logic signed [ACC_W-1:0] v;
    case (i)
      5'd0:  v = ACC_W'(2949120);
      5'd1:  v = ACC_W'(1740967);
      5'd2:  v = ACC_W'(919879);
      5'd3:  v = ACC_W'(466945);
      5'd4:  v = ACC_W'(234379);
      5'd5:  v = ACC_W'(117304);
      5'd6:  v = ACC_W'(58666);
      5'd7:  v = ACC_W'(29335);
      5'd8:  v = ACC_W'(14668);
      5'd9:  v = ACC_W'(7334);
      5'd10: v = ACC_W'(3667);
      5'd11: v = ACC_W'(1833);
      5'd12: v = ACC_W'(917);
      5'd13: v = ACC_W'(458);
      5'd14: v = ACC_W'(229);
      5'd15: v = ACC_W'(115);
      5'd16: v = ACC_W'(57);
      5'd17: v = ACC_W'(29);
      5'd18: v = ACC_W'(14);
      5'd19: v = ACC_W'(7);
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

/* design/nadt_mul.sv */
module nadt_mul (
  input  logic                                 clk,
  input  logic signed [nadt_pkg::OPND_W-1:0]   op_a,
  input  logic signed [nadt_pkg::OPND_W-1:0]   op_b,
  output logic signed [nadt_pkg::PROD_W-1:0]   prod_r
);
  import nadt_pkg::*;

  always_ff @(posedge clk) begin
    prod_r <= op_a * op_b;
  end

endmodule

/* design/nadt_isqrt.sv */
module nadt_isqrt (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [nadt_pkg::RAD_W-1:0]    radicand,
  output logic                          done,
  output logic [nadt_pkg::ROOT_W-1:0]   root
);
  import nadt_pkg::*;

  typedef enum logic [1:0] {SQ_IDLE, SQ_RUN, SQ_DONE} sq_state_t;

  sq_state_t        state_r, state_nxt;
  logic [RAD_W-1:0] rem_r, rem_nxt;
  logic [RAD_W-1:0] res_r, res_nxt;
  logic [RAD_W-1:0] bit_r, bit_nxt;
  logic [4:0]       cnt_r, cnt_nxt;
  logic [RAD_W-1:0] trial;

  assign trial = res_r + bit_r;
  assign done  = (state_r == SQ_DONE);
  assign root  = res_r[ROOT_W-1:0];

  always_comb begin
    state_nxt = state_r;
    rem_nxt   = rem_r;
    res_nxt   = res_r;
    bit_nxt   = bit_r;
    cnt_nxt   = cnt_r;
    unique case (state_r)
      SQ_IDLE: begin
        if (start) begin
          rem_nxt   = radicand;
          res_nxt   = '0;
          bit_nxt   = RAD_W'(1) << (RAD_W - 2);
          cnt_nxt   = '0;
          state_nxt = SQ_RUN;
        end
      end
      SQ_RUN: begin
        if (rem_r >= trial) begin
          rem_nxt = rem_r - trial;
          res_nxt = (res_r >> 1) + bit_r;
        end else begin
          res_nxt = res_r >> 1;
        end
        bit_nxt = bit_r >> 2;
        cnt_nxt = cnt_r + 5'd1;
        if (cnt_r == 5'd31) begin
          state_nxt = SQ_DONE;
        end
      end
      SQ_DONE: begin
        state_nxt = SQ_IDLE;
      end
      default: state_nxt = SQ_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= SQ_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    res_r <= res_nxt;
    bit_r <= bit_nxt;
  end

endmodule

/* design/nadt_cordic.sv */
module nadt_cordic (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic signed [nadt_pkg::DOT_W-1:0]   dot,
  input  logic [nadt_pkg::ROOT_W-1:0]         cross_len,
  output logic                                done,
  output nadt_pkg::angle_t                    angle
);
  import nadt_pkg::*;

  typedef enum logic [1:0] {CR_IDLE, CR_RUN, CR_DONE} cr_state_t;

  cr_state_t               state_r, state_nxt;
  logic signed [XY_W-1:0]  x_r, x_nxt, y_r, y_nxt;
  logic signed [ACC_W-1:0] acc_r, acc_nxt;
  logic [4:0]              cnt_r, cnt_nxt;
  logic signed [XY_W-1:0]  dx, dy;
  logic signed [ACC_W-1:0] acc_cl;
  logic [ACC_W-1:0]        acc_rnd;

  assign dx = y_r >>> cnt_r;
  assign dy = x_r >>> cnt_r;

  always_comb begin
    if (acc_r < 0) begin
      acc_cl = '0;
    end else if (acc_r > DEG180) begin
      acc_cl = DEG180;
    end else begin
      acc_cl = acc_r;
    end
    acc_rnd = $unsigned(acc_cl) + ACC_W'(128);
  end

  assign angle = acc_rnd[ANGLE_W+7:8];
  assign done  = (state_r == CR_DONE);

  always_comb begin
    state_nxt = state_r;
    x_nxt     = x_r;
    y_nxt     = y_r;
    acc_nxt   = acc_r;
    cnt_nxt   = cnt_r;
    unique case (state_r)
      CR_IDLE: begin
        if (start) begin
          cnt_nxt = '0;
          if (dot < 0) begin
            x_nxt   = XY_W'($signed({1'b0, cross_len}));
            y_nxt   = -XY_W'(dot);
            acc_nxt = DEG90;
          end else begin
            x_nxt   = XY_W'(dot);
            y_nxt   = XY_W'($signed({1'b0, cross_len}));
            acc_nxt = '0;
          end
          state_nxt = CR_RUN;
        end
      end
      CR_RUN: begin
        if (y_r >= 0) begin
          x_nxt   = x_r + dx;
          y_nxt   = y_r - dy;
          acc_nxt = acc_r + atan_step(cnt_r);
        end else begin
          x_nxt   = x_r - dx;
          y_nxt   = y_r + dy;
          acc_nxt = acc_r - atan_step(cnt_r);
        end
        cnt_nxt = cnt_r + 5'd1;
        if (cnt_r == 5'(CORDIC_STEPS - 1)) begin
          state_nxt = CR_DONE;
        end
      end
      CR_DONE: begin
        state_nxt = CR_IDLE;
      end
      default: state_nxt = CR_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= CR_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
    x_r   <= x_nxt;
    y_r   <= y_nxt;
    acc_r <= acc_nxt;
  end

endmodule

/* design/normal_angle_deviation_tracker.sv */
// Channel   Direction  Payload
// in_       slave      six normal components, tlast = final triangle
// out_      master     angle, largest angle, largest index; tuser = degenerate
// cfg_      write      zero-angle tolerance
// A word passes from one acceptance to the earliest next one through the shared
// multiplier, the bit-serial square root, the CORDIC unit, the hand-over of the
// result and the return to idle.
// The input is not ready while a word is in work; a waiting result stalls
// only the hand-over cycle. Reset is synchronous and clears all tracking.
`include "normal_angle_deviation_tracker_defines.svh"
module normal_angle_deviation_tracker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // first_normal_x, _y, _z, second_normal_x, _y, _z
  input  logic [95:0] in_tdata,
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  // angle_degrees, largest_angle, largest_index, zero pad
  output logic [55:0] out_tdata,
  // degenerate_normal
  output logic        out_tuser,
  output logic        out_tlast,
  input  logic        cfg_wr_en,
  input  logic [7:0]  cfg_wr_data
);
  import nadt_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_MUL, S_SQRT, S_CORDIC, S_FIN} state_t;

  state_t                   state_r, state_nxt;
  logic [3:0]               cnt_r, cnt_nxt;
  comp_t                    va_r [3];
  comp_t                    vb_r [3];
  logic                     degen_r, final_r;
  logic signed [OPND_W-1:0] c0_r, c1_r, c2_r;
  logic signed [DOT_W-1:0]  d_r;
  logic [RAD_W-1:0]         sq_r;
  logic [TOL_W-1:0]         tol_r;
  angle_t                   max_r;
  logic [IDX_W-1:0]         max_idx_r, tri_cnt_r;
  logic                     out_valid_r;
  angle_t                   o_angle_r, o_max_r;
  logic [IDX_W-1:0]         o_idx_r;
  logic                     o_degen_r, o_last_r;

  logic signed [OPND_W-1:0] op_a, op_b;
  logic signed [PROD_W-1:0] prod;
  logic signed [OPND_W-1:0] p33;
  logic                     sqrt_start, sqrt_done, cordic_done;
  logic [ROOT_W-1:0]        root;
  angle_t                   cordic_angle, angle_fin;
  logic [IDX_W-1:0]         item_idx;
  logic                     load_out, accept;

  assign in_tready = (state_r == S_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign p33       = prod[OPND_W-1:0];

  always_comb begin
    op_a = '0;
    op_b = '0;
    case (cnt_r)
      4'd0:  begin op_a = OPND_W'(va_r[1]); op_b = OPND_W'(vb_r[2]); end
      4'd1:  begin op_a = OPND_W'(va_r[2]); op_b = OPND_W'(vb_r[1]); end
      4'd2:  begin op_a = OPND_W'(va_r[2]); op_b = OPND_W'(vb_r[0]); end
      4'd3:  begin op_a = OPND_W'(va_r[0]); op_b = OPND_W'(vb_r[2]); end
      4'd4:  begin op_a = OPND_W'(va_r[0]); op_b = OPND_W'(vb_r[1]); end
      4'd5:  begin op_a = OPND_W'(va_r[1]); op_b = OPND_W'(vb_r[0]); end
      4'd6:  begin op_a = OPND_W'(va_r[0]); op_b = OPND_W'(vb_r[0]); end
      4'd7:  begin op_a = OPND_W'(va_r[1]); op_b = OPND_W'(vb_r[1]); end
      4'd8:  begin op_a = OPND_W'(va_r[2]); op_b = OPND_W'(vb_r[2]); end
      4'd9:  begin op_a = c0_r; op_b = c0_r; end
      4'd10: begin op_a = c1_r; op_b = c1_r; end
      4'd11: begin op_a = c2_r; op_b = c2_r; end
      default: begin op_a = '0; op_b = '0; end
    endcase
  end

  nadt_mul u_mul (
    .clk    (clk),
    .op_a   (op_a),
    .op_b   (op_b),
    .prod_r (prod)
  );

  assign sqrt_start = (state_r == S_SQRT);

  nadt_isqrt u_isqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (sqrt_start),
    .radicand (sq_r),
    .done     (sqrt_done),
    .root     (root)
  );

  nadt_cordic u_cordic (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (sqrt_done),
    .dot       (d_r),
    .cross_len (root),
    .done      (cordic_done),
    .angle     (cordic_angle)
  );

  always_comb begin
    if (degen_r || (cordic_angle <= ANGLE_W'(tol_r))) begin
      angle_fin = '0;
    end else begin
      angle_fin = cordic_angle;
    end
    if (tri_cnt_r >= MAX_TRIANGLES) begin
      item_idx = MAX_TRIANGLES;
    end else begin
      item_idx = tri_cnt_r + IDX_W'(1);
    end
  end

  assign load_out = (state_r == S_FIN) && (!out_valid_r || out_tready);

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          cnt_nxt   = '0;
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        cnt_nxt = cnt_r + 4'd1;
        if (cnt_r == 4'(MUL_OPS)) begin
          state_nxt = S_SQRT;
        end
      end
      S_SQRT: begin
        if (sqrt_done) begin
          state_nxt = S_CORDIC;
        end
      end
      S_CORDIC: begin
        if (cordic_done) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (load_out) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      tol_r       <= TOL_W'(1);
      max_r       <= '0;
      max_idx_r   <= '0;
      tri_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      if (cfg_wr_en) begin
        tol_r <= cfg_wr_data;
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
        if (final_r) begin
          max_r     <= '0;
          max_idx_r <= '0;
          tri_cnt_r <= '0;
        end else begin
          if (angle_fin > max_r) begin
            max_r     <= angle_fin;
            max_idx_r <= item_idx;
          end
          if (tri_cnt_r < MAX_TRIANGLES) begin
            tri_cnt_r <= tri_cnt_r + IDX_W'(1);
          end
        end
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
    if (accept) begin
      va_r[0] <= in_tdata[15:0];
      va_r[1] <= in_tdata[31:16];
      va_r[2] <= in_tdata[47:32];
      vb_r[0] <= in_tdata[63:48];
      vb_r[1] <= in_tdata[79:64];
      vb_r[2] <= in_tdata[95:80];
      degen_r <= (in_tdata[47:0] == '0) || (in_tdata[95:48] == '0);
      final_r <= in_tlast;
    end
    if (state_r == S_MUL) begin
      case (cnt_r)
        4'd1:  c0_r <= p33;
        4'd2:  c0_r <= c0_r - p33;
        4'd3:  c1_r <= p33;
        4'd4:  c1_r <= c1_r - p33;
        4'd5:  c2_r <= p33;
        4'd6:  c2_r <= c2_r - p33;
        4'd7:  d_r  <= DOT_W'(p33);
        4'd8:  d_r  <= d_r + DOT_W'(p33);
        4'd9:  d_r  <= d_r + DOT_W'(p33);
        4'd10: sq_r <= prod[RAD_W-1:0];
        4'd11: sq_r <= sq_r + prod[RAD_W-1:0];
        4'd12: sq_r <= sq_r + prod[RAD_W-1:0];
        default: ;
      endcase
    end
    if (load_out) begin
      o_angle_r <= angle_fin;
      o_degen_r <= degen_r;
      o_last_r  <= final_r;
      if (angle_fin > max_r) begin
        o_max_r <= angle_fin;
        o_idx_r <= item_idx;
      end else begin
        o_max_r <= max_r;
        o_idx_r <= max_idx_r;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, o_idx_r, o_max_r, o_angle_r};
  assign out_tuser  = o_degen_r;
  assign out_tlast  = o_last_r;

  `NADT_ASSERT_NXT(a_busy_after_accept, accept, !in_tready, "input ready after accept")
  `NADT_ASSERT_IMP(a_max_covers_angle, out_valid_r, o_max_r >= o_angle_r, "largest below angle")
  `NADT_ASSERT_IMP(a_degen_zero, out_valid_r && o_degen_r, o_angle_r == '0, "degenerate angle set")
  `NADT_ASSERT_IMP(a_max_has_index, out_valid_r && (o_max_r != '0), o_idx_r != '0, "largest lacks index")

endmodule
